// File: rtl/core/mavg_pkg.sv
// Package for the boxcar moving average filter.
// Holds the fixed field widths, register indexes, input codes and the controller state type.
// No dependencies.
package mavg_pkg;

	// Width of samples, the init value and the average (signed Q12.4).
	localparam int DATA_W = 16;
	// Width of the order register.
	localparam int ORDER_W = 6;
	// Width of the configuration register index.
	localparam int REG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ORDER = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_INIT  = 1'b1;

	// Input item modes.
	localparam logic MODE_SAMPLE  = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	// Saturation limits of the average.
	localparam logic signed [DATA_W-1:0] AVG_MAX = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] AVG_MIN = 16'sh8000;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

// File: rtl/core/mavg_in_if.sv
// Input channel of the moving average filter: valid/ready handshake with mode and sample.
// Depends on mavg_pkg.
interface mavg_in_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic signed [mavg_pkg::DATA_W-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink (input valid, input mode, input sample, output ready);
endinterface

// File: rtl/core/mavg_out_if.sv
// Output channel of the moving average filter: valid/ready handshake with the average.
// Depends on mavg_pkg.
interface mavg_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [mavg_pkg::DATA_W-1:0] average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

// File: rtl/core/mavg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/mavg_div.sv
// Bit-serial restoring divider: signed sum over an unsigned order, truncated toward zero,
// saturated to the Q12.4 range. Depends on mavg_pkg.
module mavg_div #(
	parameter int SUM_W = 21,
	parameter int DIV_W = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [SUM_W-1:0]             sum,
	input  logic [DIV_W-1:0]                    divisor,
	output logic                                done,
	output logic signed [mavg_pkg::DATA_W-1:0]  average
);

	localparam int CW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]                    quo_q;
	logic [DIV_W-1:0]                    rem_q;
	logic                                neg_q;
	logic [CW-1:0]                       cnt_q;
	logic                                busy_q;
	logic                                fin_q;
	logic                                done_q;
	logic signed [mavg_pkg::DATA_W-1:0]  avg_q;

	logic [SUM_W-1:0]                    mag;
	logic [DIV_W:0]                      trial;
	logic [DIV_W:0]                      diff;
	logic                                ge;
	logic [SUM_W-1:0]                    quo_neg;
	logic signed [mavg_pkg::DATA_W-1:0]  sat;

	// The magnitude of the most negative sum still fits as an unsigned value.
	assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	// One quotient bit per cycle: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	assign quo_neg = SUM_W'(-quo_q);

	always_comb begin
		if (!neg_q) begin
			if (quo_q > SUM_W'(32767)) begin
				sat = mavg_pkg::AVG_MAX;
			end else begin
				sat = quo_q[mavg_pkg::DATA_W-1:0];
			end
		end else begin
			if (quo_q > SUM_W'(32768)) begin
				sat = mavg_pkg::AVG_MIN;
			end else begin
				sat = quo_neg[mavg_pkg::DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(SUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= sum[SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
		if (fin_q) begin
			avg_q <= sat;
		end
	end

	assign done    = done_q;
	assign average = avg_q;

endmodule

// File: rtl/core/moving_average_filter.sv
// Top level of the boxcar moving average filter over signed Q12.4 samples.
// Depends on mavg_pkg, mavg_in_if, mavg_out_if, mavg_ram and mavg_div.
//
// This block averages the last N samples, where N is the order register (an order of zero
// acts as one, an order above MAX_ORDER acts as MAX_ORDER). Each input transaction either
// carries a new sample (mode 0) or restarts the filter (mode 1); every input transaction
// produces exactly one output transaction with the average, truncated toward zero and
// saturated to the 16-bit range. After a restart the history reads as the init value until
// it is overwritten, and the average equals the init value. The history lives in a RAM of
// MAX_ORDER entries; a running sum of SUM_W = 16 + log2(MAX_ORDER) bits wraps on overflow.
// From acceptance to the output register a sample transaction passes the states READ,
// START, DIV and OUT; a restart skips the history read in READ. Most of that time is spent
// in the bit-serial divider, which produces one quotient bit per cycle. The input is ready
// again as soon as the result is in the output register, so the next item can be taken
// while the previous result waits.
// Configuration registers are written through wr_en, wr_index and wr_data and must only be
// changed while no item is in flight. There is no clearing pass after reset.
module moving_average_filter #(
	parameter int MAX_ORDER = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mavg_in_if.sink                             item,
	mavg_out_if.source                          result,
	input  logic                                wr_en,
	input  logic [mavg_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [mavg_pkg::DATA_W-1:0]         wr_data
);

	localparam int DW    = mavg_pkg::DATA_W;
	localparam int PW    = $clog2(MAX_ORDER);
	localparam int NW    = $clog2(MAX_ORDER + 1);
	localparam int SUM_W = DW + PW;

	mavg_pkg::state_t state_q;

	// Configuration registers.
	logic [mavg_pkg::ORDER_W-1:0] order_q;
	logic signed [DW-1:0]         init_q;

	// Filter state.
	logic signed [SUM_W-1:0] sum_q;
	logic [PW-1:0]           pos_q;
	logic [NW-1:0]           filled_q;
	logic [NW-1:0]           n_q;
	logic signed [DW-1:0]    x_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [DW-1:0]    average_q;

	logic [NW-1:0]           eff_order;
	logic [PW-1:0]           pos_use;
	logic signed [NW+DW:0]   prod;
	logic [NW-1:0]           pos_inc;
	logic signed [DW-1:0]    old;
	logic [DW-1:0]           ram_rdata;
	logic                    accept;
	logic                    out_free;
	logic                    div_done;
	logic signed [DW-1:0]    div_avg;

	// Clamp the order to the range the history can hold.
	always_comb begin
		if (order_q == '0) begin
			eff_order = NW'(1);
		end else if (32'(order_q) > MAX_ORDER) begin
			eff_order = NW'(MAX_ORDER);
		end else begin
			eff_order = NW'(order_q);
		end
	end

	assign item.ready = (state_q == mavg_pkg::ST_IDLE);
	assign accept     = item.valid && item.ready;

	// If the order shrank since the last sample, the write position wraps to zero first.
	assign pos_use = (NW'(pos_q) >= eff_order) ? '0 : pos_q;

	// Restart loads the sum as if every entry held the init value.
	assign prod = $signed({1'b0, eff_order}) * init_q;

	assign pos_inc = NW'(pos_q) + NW'(1);

	// Entries beyond the fill level have not been written since the restart.
	assign old = (NW'(pos_q) < filled_q) ? $signed(ram_rdata) : init_q;

	assign out_free = !out_valid_q || result.ready;

	mavg_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ORDER)
	) u_history (
		.clk   (clk),
		.we    (state_q == mavg_pkg::ST_READ),
		.waddr (pos_q),
		.wdata (x_q),
		.re    (accept && (item.mode == mavg_pkg::MODE_SAMPLE)),
		.raddr (pos_use),
		.rdata (ram_rdata)
	);

	mavg_div #(
		.SUM_W (SUM_W),
		.DIV_W (NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == mavg_pkg::ST_START),
		.sum     (sum_q),
		.divisor (n_q),
		.done    (div_done),
		.average (div_avg)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= mavg_pkg::ORDER_W'(1);
			init_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mavg_pkg::REG_ORDER: order_q <= wr_data[mavg_pkg::ORDER_W-1:0];
				mavg_pkg::REG_INIT:  init_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Controller: accept, update the history and sum, divide, then hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mavg_pkg::ST_IDLE;
			sum_q       <= '0;
			pos_q       <= '0;
			filled_q    <= '0;
			n_q         <= NW'(1);
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the output register as soon as the old one has left.
			if ((state_q == mavg_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mavg_pkg::ST_IDLE: begin
					if (accept) begin
						n_q <= eff_order;
						if (item.mode == mavg_pkg::MODE_RESTART) begin
							sum_q    <= prod[SUM_W-1:0];
							pos_q    <= '0;
							filled_q <= '0;
							state_q  <= mavg_pkg::ST_START;
						end else begin
							pos_q   <= pos_use;
							state_q <= mavg_pkg::ST_READ;
						end
					end
				end
				mavg_pkg::ST_READ: begin
					sum_q <= sum_q - SUM_W'(old) + SUM_W'(x_q);
					if (pos_inc > filled_q) begin
						filled_q <= pos_inc;
					end
					pos_q   <= (pos_inc >= n_q) ? '0 : pos_inc[PW-1:0];
					state_q <= mavg_pkg::ST_START;
				end
				mavg_pkg::ST_START: begin
					state_q <= mavg_pkg::ST_DIV;
				end
				mavg_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= mavg_pkg::ST_OUT;
					end
				end
				mavg_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= mavg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mavg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= item.sample;
		end
		if ((state_q == mavg_pkg::ST_OUT) && out_free) begin
			average_q <= div_avg;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.average = average_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for moving_average_filter, the boxcar average of signed Q12.4 samples.
// Depends on mavg_pkg, mavg_in_if, mavg_out_if and the filter RTL below them; every average is
// checked against a typed-in value or a model of the ring store and running sum kept in this file.
module testbench;

	// Depth of the filter under test and width of its running sum (16 + log2 of the depth).
	localparam int FILTER_DEPTH = 32;
	localparam int SUM_W = 21;
	// Length of the long receiver hold that forces the block to stall its input.
	localparam int HOLD_CYCLES = 400;
	// Random part: phases of stimulus, each with its own register setting and idling pattern.
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 130;
	// Cycles waited after the last owed average has arrived.
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS = 33;

	// A directed row is either an item for the filter or a write to one of the two registers.
	typedef enum logic [1:0] {ROW_ITEM, ROW_ORDER, ROW_INIT} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		logic                         mode;
		logic [mavg_pkg::DATA_W-1:0]  value;
		bit                           typed;
		logic [mavg_pkg::DATA_W-1:0]  avg;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [mavg_pkg::REG_IDX_W-1:0] wr_index;
	logic [mavg_pkg::DATA_W-1:0] wr_data;

	mavg_in_if  in_ch();
	mavg_out_if out_ch();

	moving_average_filter #(
		.MAX_ORDER(FILTER_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_ch),
		.result   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #10 clk = ~clk;

	// Mirror of the registers and of the filter state. The registers are updated when the
	// testbench writes them; the state is updated by predict_average for each accepted item.
	logic [mavg_pkg::ORDER_W-1:0]       mirror_order = 6'd1;
	logic signed [mavg_pkg::DATA_W-1:0] mirror_init = '0;
	logic signed [mavg_pkg::DATA_W-1:0] ring_mem [FILTER_DEPTH];
	logic signed [SUM_W-1:0]            box_sum = '0;
	int                                 ring_pos = 0;
	int                                 ring_fill = 0;

	// Averages still owed by the block, oldest first.
	logic [mavg_pkg::DATA_W-1:0] avg_expect_q[$];
	int mismatch_count = 0;

	// Idling pattern of the current phase, in percent of cycles.
	int unsigned src_pct = 0;
	int unsigned sink_pct = 0;

	// The main process asks for a long receiver hold by bumping hold_requests; the receiver
	// process notices the change and counts the hold out in cycles on its own.
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	// Directed stimulus. Averages are typed in only where they follow at a glance: order 1
	// passes samples through, a restart returns the init value, and the saturated cases. The
	// rows in between cover an order of zero (acts as one), orders above the depth (act as
	// the depth), unfilled entries reading the init value, the init value changed without a
	// restart so that the sum wraps, and the order shrunk while the write position is past it.
	// Some order writes carry junk above bit 5, which the register drops.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b1, 16'h7FFF},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h8000, 1'b1, 16'h8000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'h5A5A, 1'b1, 16'h0000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'hAB40, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h0001, 1'b1, 16'h0001},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'hFFFF, 1'b1, 16'hFFFF},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h003F, 1'b0, 16'h0000},
		'{ROW_INIT,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'hFFFF, 1'b1, 16'h7FFF},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b1, 16'h7FFF},
		'{ROW_INIT,  mavg_pkg::MODE_SAMPLE,  16'h8000, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h8000, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'h0000, 1'b1, 16'h8000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h8000, 1'b1, 16'h8000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b0, 16'h0000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h0003, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'h1234, 1'b1, 16'h8000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h0064, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h00C8, 1'b0, 16'h0000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h0001, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h0010, 1'b0, 16'h0000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h5420, 1'b0, 16'h0000},
		'{ROW_INIT,  mavg_pkg::MODE_SAMPLE,  16'h7FFF, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'h0000, 1'b1, 16'h7FFF},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h0001, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h0000, 1'b1, 16'h7FFF},
		'{ROW_INIT,  mavg_pkg::MODE_SAMPLE,  16'h8000, 1'b0, 16'h0000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h0020, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_RESTART, 16'h0000, 1'b1, 16'h8000},
		'{ROW_ORDER, mavg_pkg::MODE_SAMPLE,  16'h0001, 1'b0, 16'h0000},
		'{ROW_ITEM,  mavg_pkg::MODE_SAMPLE,  16'h0000, 1'b1, 16'h8000},
		'{ROW_INIT,  mavg_pkg::MODE_SAMPLE,  16'h0000, 1'b0, 16'h0000}
	};

	// Advances the mirrored filter by one item and returns the average it must produce.
	// The effective order clamps zero to one and large values to the depth. A restart empties
	// the store and loads the sum with order times init; a sample swaps the oldest entry (or
	// the init value, for an entry not yet written) for the new one. The sum wraps at SUM_W
	// bits, and the quotient truncates toward zero and saturates to 16 bits.
	function automatic logic [mavg_pkg::DATA_W-1:0] predict_average(input logic m,
			input logic signed [mavg_pkg::DATA_W-1:0] s);
		int n;
		logic signed [31:0] acc;
		logic signed [mavg_pkg::DATA_W-1:0] oldest;
		if (mirror_order == 0)
			n = 1;
		else if (mirror_order > FILTER_DEPTH)
			n = FILTER_DEPTH;
		else
			n = int'(mirror_order);
		if (m == mavg_pkg::MODE_RESTART) begin
			ring_pos = 0;
			ring_fill = 0;
			acc = n * mirror_init;
			box_sum = acc[SUM_W-1:0];
		end else begin
			// A shrunken order can leave the write position past the end of the window.
			if (ring_pos >= n)
				ring_pos = 0;
			oldest = (ring_pos < ring_fill) ? ring_mem[ring_pos] : mirror_init;
			acc = box_sum - oldest + s;
			box_sum = acc[SUM_W-1:0];
			ring_mem[ring_pos] = s;
			if (ring_pos + 1 > ring_fill)
				ring_fill = ring_pos + 1;
			ring_pos++;
			if (ring_pos >= n)
				ring_pos = 0;
		end
		acc = box_sum / n;
		if (acc > 32'sd32767)
			return mavg_pkg::AVG_MAX;
		if (acc < -32'sd32768)
			return mavg_pkg::AVG_MIN;
		return acc[mavg_pkg::DATA_W-1:0];
	endfunction

	// Offers one item after the idle cycles of the current phase and waits for the transaction.
	// Inputs change only at the falling edge; ready is sampled at the rising edge. The average
	// owed for the item is queued as soon as it is accepted.
	task automatic send_item(input logic m, input logic [mavg_pkg::DATA_W-1:0] s,
			input bit typed, input logic [mavg_pkg::DATA_W-1:0] typed_avg);
		logic [mavg_pkg::DATA_W-1:0] predicted;
		@(negedge clk);
		while ($urandom_range(99) < src_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.sample <= s;
		do @(posedge clk); while (!in_ch.ready);
		predicted = predict_average(m, s);
		avg_expect_q.push_back(typed ? typed_avg : predicted);
	endtask

	// Writes one register once the block has drained: every item yields an average, so an
	// empty queue means nothing is in flight. A few extra cycles keep well clear of the edge.
	task automatic write_reg(input logic [mavg_pkg::REG_IDX_W-1:0] idx,
			input logic [mavg_pkg::DATA_W-1:0] data);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (avg_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		if (idx == mavg_pkg::REG_ORDER)
			mirror_order = data[mavg_pkg::ORDER_W-1:0];
		else
			mirror_init = data;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Receiver: either a counted long hold, or random stalls at the rate of the current phase.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_pct);
		end
	end

	// Checker: every output transaction must match the oldest average still owed.
	always @(posedge clk) begin
		logic [mavg_pkg::DATA_W-1:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (avg_expect_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected average, expected none, got %0d", $time,
					$signed(out_ch.average));
			end else begin
				want = avg_expect_q.pop_front();
				if (out_ch.average !== want) begin
					mismatch_count++;
					$display("%0t: average mismatch, expected %0d, got %0d", $time,
						$signed(want), $signed(out_ch.average));
				end
			end
		end
	end

	initial begin
		logic [mavg_pkg::DATA_W-1:0] wdata;
		logic [mavg_pkg::ORDER_W-1:0] ord;
		logic m;
		logic [mavg_pkg::DATA_W-1:0] s;

		in_ch.valid = 1'b0;
		in_ch.mode = mavg_pkg::MODE_SAMPLE;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = mavg_pkg::REG_ORDER;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_ITEM: begin
					send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed,
						dir_rows[i].avg);
				end
				ROW_ORDER: begin
					write_reg(mavg_pkg::REG_ORDER, dir_rows[i].value);
				end
				default: begin
					write_reg(mavg_pkg::REG_INIT, dir_rows[i].value);
				end
			endcase
		end

		// Random phases. Each phase picks a new order and init value without a restart, so
		// the sum carries over from the previous setting, and takes the next of the idling
		// patterns in turn: none, sender idle, receiver stalling, and a little of both.
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(5))
				0: ord = 6'd0;
				1: ord = 6'd1;
				2: ord = 6'd32;
				3: ord = 6'($urandom_range(63, 33));
				default: ord = 6'($urandom_range(31, 2));
			endcase
			wdata = 16'($urandom());
			wdata[mavg_pkg::ORDER_W-1:0] = ord;
			write_reg(mavg_pkg::REG_ORDER, wdata);
			case ($urandom_range(4))
				0: wdata = 16'h7FFF;
				1: wdata = 16'h8000;
				default: wdata = 16'($urandom());
			endcase
			write_reg(mavg_pkg::REG_INIT, wdata);

			case (ph % 4)
				0: begin
					src_pct = 0;
					sink_pct = 0;
				end
				1: begin
					src_pct = 87;
					sink_pct = 0;
				end
				2: begin
					src_pct = 0;
					sink_pct = 87;
				end
				default: begin
					src_pct = 6;
					sink_pct = 6;
				end
			endcase
			// With the sender offering back to back, a long hold fills the output register
			// and the divider, so the block has to stall its input.
			if (ph == 0)
				hold_requests++;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				m = ($urandom_range(11) == 0) ? mavg_pkg::MODE_RESTART : mavg_pkg::MODE_SAMPLE;
				case ($urandom_range(15))
					0: s = 16'h7FFF;
					1: s = 16'h8000;
					2: s = 16'h0000;
					3: s = 16'hFFFF;
					default: s = 16'($urandom());
				endcase
				send_item(m, s, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && avg_expect_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: the slowest correct run needs well under a millisecond of simulated time.
	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
